[rtl/tsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, constants and the 2^(i/16) fraction table of the transient
// shaper gain block.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CHANNELS   = 2;
    localparam int IN_W       = CHANNELS * SAMPLE_W;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = CHANNELS * SAMPLE_W + GAIN_W;
    localparam int COEF_W     = 24;
    localparam int ENV_W      = 24;
    localparam int SENS_W     = 13;
    localparam int OGAIN_W    = 14;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int MANT_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier: signed operands wide enough for coef * (env - peak)
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [MUL_W-1:0] LOG2_DB_K = 26'd2786635;
    localparam logic signed [17:0] GAIN_MAX = 18'sd18432;
    localparam logic signed [17:0] GAIN_MIN = -18'sd18432;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ATTACK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_SENS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_SENS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 3'd6;

    // register reset values
    localparam logic [COEF_W-1:0] RST_FAST_ATTACK  = 24'd16661113;
    localparam logic [COEF_W-1:0] RST_FAST_RELEASE = 24'd16765569;
    localparam logic [COEF_W-1:0] RST_SLOW_ATTACK  = 24'd16774886;
    localparam logic [COEF_W-1:0] RST_SLOW_RELEASE = 24'd16776342;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST,
        ST_SLOW,
        ST_SLOW_UPD,
        ST_ATT,
        ST_SUS,
        ST_ACC,
        ST_GAIN,
        ST_EXP,
        ST_SPLIT,
        ST_INTERP,
        ST_MANT,
        ST_LEFT,
        ST_RIGHT,
        ST_DONE
    } seq_state_t;

    // 2^(idx/16) in Q16
    function automatic logic [MANT_W-1:0] exp_frac(input logic [4:0] idx);
        logic [MANT_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 18'd65536;
                5'd1:    val = 18'd68438;
                5'd2:    val = 18'd71468;
                5'd3:    val = 18'd74632;
                5'd4:    val = 18'd77936;
                5'd5:    val = 18'd81386;
                5'd6:    val = 18'd84990;
                5'd7:    val = 18'd88752;
                5'd8:    val = 18'd92682;
                5'd9:    val = 18'd96785;
                5'd10:   val = 18'd101070;
                5'd11:   val = 18'd105545;
                5'd12:   val = 18'd110218;
                5'd13:   val = 18'd115098;
                5'd14:   val = 18'd120194;
                5'd15:   val = 18'd125515;
                5'd16:   val = 18'd131072;
                default: val = 18'd131072;
            endcase
            return val;
        end
    endfunction

endpackage

[rtl/tsg_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_mul
// Shared signed multiplier with a registered product; the product holds
// while the enable is low.
// ----------------------------------------------------------------------------
module tsg_mul (
    input  logic              clk,
    input  logic              en,
    input  tsg_pkg::mul_op_t  op_a,
    input  tsg_pkg::mul_op_t  op_b,
    output tsg_pkg::mul_prod_t prod
);
    import tsg_pkg::*;

    mul_prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/transient_shaper_gain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transient_shaper_gain
// Linked-stereo transient shaper: dual envelope follower, dB gain, linear
// scaling with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stereo frame per item: tdata = {right, left}.
//   m_axis returns one item per frame: tdata = {gain_db, right, left}.
//   cfg_* writes one register (index, data) per handshake; cfg_ready is
//   always high. Write registers only while no frame is in flight.
//   s_axis_tready is high only while the sequencer is idle. After an item
//   is accepted, the sequencer steps through its states to the result on
//   m_axis, and the next item can be accepted only once it is back in idle.
//   The pace is set by one shared multiplier that forms eight products in
//   turn (two envelope updates, two gain terms, the dB-to-log2 scale, the
//   table interpolation and one scaling per channel).
//   The output register holds its item until m_axis_tready; a new frame is
//   still taken and worked on meanwhile, and the sequencer waits in its last
//   step only if the previous result has not been taken yet.
//   Reset clears both envelopes, loads the register defaults and drops
//   m_axis_tvalid.
// ----------------------------------------------------------------------------
module transient_shaper_gain (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream: [15:0] left_sample, [31:16] right_sample
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tsg_pkg::IN_W-1:0]          s_axis_tdata,
    // master stream: [15:0] left_out, [31:16] right_out, [47:32] gain_db
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tsg_pkg::OUT_W-1:0]         m_axis_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tsg_pkg::*;

    // configuration registers
    logic [COEF_W-1:0]         fast_attack_reg;
    logic [COEF_W-1:0]         fast_release_reg;
    logic [COEF_W-1:0]         slow_attack_reg;
    logic [COEF_W-1:0]         slow_release_reg;
    logic signed [SENS_W-1:0]  att_sens_reg;
    logic signed [SENS_W-1:0]  sus_sens_reg;
    logic signed [OGAIN_W-1:0] out_gain_reg;

    // state
    seq_state_t state_reg;
    seq_state_t state_next;
    logic [ENV_W-1:0] fast_env_reg;
    logic [ENV_W-1:0] slow_env_reg;

    // per-item working registers
    logic [MAG_W-1:0]          mag_l_reg;
    logic [MAG_W-1:0]          mag_r_reg;
    logic                      neg_l_reg;
    logic                      neg_r_reg;
    logic [ENV_W-1:0]          pk_reg;
    logic signed [39:0]        acc_reg;
    logic signed [GAIN_W-1:0]  gain_reg;
    logic signed [5:0]         exp_n_reg;
    logic [3:0]                frac_i_reg;
    logic [11:0]               frac_r_reg;
    logic [MANT_W-1:0]         mant_reg;
    logic [SAMPLE_W-1:0]       left_res_reg;

    // output register
    logic                      out_valid_reg;
    logic [SAMPLE_W-1:0]       out_left_reg;
    logic [SAMPLE_W-1:0]       out_right_reg;
    logic [GAIN_W-1:0]         out_gain_db_reg;

    // shared multiplier
    logic      mul_en;
    mul_op_t   op_a;
    mul_op_t   op_b;
    mul_prod_t prod;

    // input side
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic [MAG_W-1:0]           in_mag_l;
    logic [MAG_W-1:0]           in_mag_r;
    logic [MAG_W-1:0]           in_peak;

    logic                      in_accept;
    logic                      out_free;
    logic [COEF_W-1:0]         fast_coef;
    logic [COEF_W-1:0]         slow_coef;
    logic [MUL_W-1:0]          fast_diff;
    logic [MUL_W-1:0]          slow_diff;
    logic [MUL_W-1:0]          trans;
    logic [PROD_W-1:0]         env_sum;
    logic [ENV_W-1:0]          env_upd;
    logic [40:0]               gain_sum;
    logic signed [17:0]        gain_raw;
    logic signed [GAIN_W-1:0]  gain_clamp;
    logic signed [16:0]        total_db;
    logic [PROD_W-1:0]         exp_sum;
    logic [MANT_W-1:0]         tab_base;
    logic [MANT_W-1:0]         tab_next;
    logic [12:0]               tab_diff;
    logic [25:0]               interp_rnd;
    logic [SAMPLE_W-1:0]       scaled;

    // rounded shift by 2^(n-16), then saturation to a signed sample
    function automatic logic [SAMPLE_W-1:0] scale_sat(
        input logic [34:0]       p,
        input logic signed [5:0] n,
        input logic              neg
    );
        logic [36:0]         q;
        logic [34:0]         t;
        logic [5:0]          lsh;
        logic [5:0]          rsh;
        logic [SAMPLE_W-1:0] res;
        begin
            lsh = 6'(n - 6'sd16);
            rsh = 6'(6'sd15 - n);
            t   = p >> rsh;
            if (n >= 6'sd16)
            begin
                q = {2'b00, p} << lsh;
            end
            else
            begin
                q = ({2'b00, t} + 37'd1) >> 1;
            end
            if (neg)
            begin
                if (q > 37'd32768)
                begin
                    res = 16'h8000;
                end
                else
                begin
                    res = 16'(37'd0 - q);
                end
            end
            else
            begin
                if (q > 37'd32767)
                begin
                    res = 16'h7FFF;
                end
                else
                begin
                    res = q[15:0];
                end
            end
            return res;
        end
    endfunction

    tsg_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign in_left  = s_axis_tdata[SAMPLE_W-1:0];
    assign in_right = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign in_mag_l = in_left[SAMPLE_W-1]  ? (MAG_W'(0) - {in_left[SAMPLE_W-1], in_left})
                                           : {1'b0, in_left};
    assign in_mag_r = in_right[SAMPLE_W-1] ? (MAG_W'(0) - {in_right[SAMPLE_W-1], in_right})
                                           : {1'b0, in_right};
    assign in_peak  = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_gain_db_reg, out_right_reg, out_left_reg};

    // follower coefficient: attack while the peak rises above the envelope
    assign fast_coef = (pk_reg > fast_env_reg) ? fast_attack_reg : fast_release_reg;
    assign slow_coef = (pk_reg > slow_env_reg) ? slow_attack_reg : slow_release_reg;
    assign fast_diff = {2'b00, fast_env_reg} - {2'b00, pk_reg};
    assign slow_diff = {2'b00, slow_env_reg} - {2'b00, pk_reg};
    assign trans     = {2'b00, fast_env_reg} - {2'b00, slow_env_reg};

    // env' = pk + c * (env - pk), rounded, in Q.24
    assign env_sum = prod + (PROD_W'(pk_reg) << 24) + (PROD_W'(1) << 23);
    assign env_upd = env_sum[47:24];

    // 3 * acc, rounded by 2^22, arithmetic shift by 23
    assign gain_sum = {acc_reg[39], acc_reg} + {acc_reg, 1'b0} + 41'd4194304;
    assign gain_raw = gain_sum[40:23];
    always_comb
    begin
        if (gain_raw > GAIN_MAX)
        begin
            gain_clamp = GAIN_MAX[GAIN_W-1:0];
        end
        else if (gain_raw < GAIN_MIN)
        begin
            gain_clamp = GAIN_MIN[GAIN_W-1:0];
        end
        else
        begin
            gain_clamp = gain_raw[GAIN_W-1:0];
        end
    end

    assign total_db = {gain_reg[GAIN_W-1], gain_reg}
                    + {{3{out_gain_reg[OGAIN_W-1]}}, out_gain_reg};
    assign exp_sum  = prod + PROD_W'(32768);

    assign tab_base   = exp_frac({1'b0, frac_i_reg});
    assign tab_next   = exp_frac({1'b0, frac_i_reg} + 5'd1);
    assign tab_diff   = 13'(tab_next - tab_base);
    assign interp_rnd = prod[25:0] + 26'd2048;

    assign scaled = scale_sat(prod[34:0], exp_n_reg,
                              (state_reg == ST_RIGHT) ? neg_l_reg : neg_r_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        op_a       = '0;
        op_b       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_FAST;
                end
            end
            ST_FAST:
            begin
                mul_en     = 1'b1;
                op_a       = {2'b00, fast_coef};
                op_b       = fast_diff;
                state_next = ST_SLOW;
            end
            ST_SLOW:
            begin
                mul_en     = 1'b1;
                op_a       = {2'b00, slow_coef};
                op_b       = slow_diff;
                state_next = ST_SLOW_UPD;
            end
            ST_SLOW_UPD:
            begin
                state_next = ST_ATT;
            end
            ST_ATT:
            begin
                mul_en     = 1'b1;
                op_a       = {{(MUL_W-SENS_W){att_sens_reg[SENS_W-1]}}, att_sens_reg};
                op_b       = trans;
                state_next = ST_SUS;
            end
            ST_SUS:
            begin
                mul_en     = 1'b1;
                op_a       = {{(MUL_W-SENS_W){sus_sens_reg[SENS_W-1]}}, sus_sens_reg};
                op_b       = {2'b00, slow_env_reg};
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                mul_en     = 1'b1;
                op_a       = {{(MUL_W-17){total_db[16]}}, total_db};
                op_b       = LOG2_DB_K;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                mul_en     = 1'b1;
                op_a       = {13'd0, tab_diff};
                op_b       = {14'd0, frac_r_reg};
                state_next = ST_MANT;
            end
            ST_MANT:
            begin
                state_next = ST_LEFT;
            end
            ST_LEFT:
            begin
                mul_en     = 1'b1;
                op_a       = {{(MUL_W-MAG_W){1'b0}}, mag_l_reg};
                op_b       = {{(MUL_W-MANT_W){1'b0}}, mant_reg};
                state_next = ST_RIGHT;
            end
            ST_RIGHT:
            begin
                mul_en     = 1'b1;
                op_a       = {{(MUL_W-MAG_W){1'b0}}, mag_r_reg};
                op_b       = {{(MUL_W-MANT_W){1'b0}}, mant_reg};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration registers, envelopes and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_attack_reg  <= RST_FAST_ATTACK;
            fast_release_reg <= RST_FAST_RELEASE;
            slow_attack_reg  <= RST_SLOW_ATTACK;
            slow_release_reg <= RST_SLOW_RELEASE;
            att_sens_reg     <= '0;
            sus_sens_reg     <= '0;
            out_gain_reg     <= '0;
            fast_env_reg     <= '0;
            slow_env_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FAST_ATTACK:  fast_attack_reg  <= cfg_data[COEF_W-1:0];
                    CFG_FAST_RELEASE: fast_release_reg <= cfg_data[COEF_W-1:0];
                    CFG_SLOW_ATTACK:  slow_attack_reg  <= cfg_data[COEF_W-1:0];
                    CFG_SLOW_RELEASE: slow_release_reg <= cfg_data[COEF_W-1:0];
                    CFG_ATTACK_SENS:  att_sens_reg     <= cfg_data[SENS_W-1:0];
                    CFG_SUSTAIN_SENS: sus_sens_reg     <= cfg_data[SENS_W-1:0];
                    CFG_OUTPUT_GAIN:  out_gain_reg     <= cfg_data[OGAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_SLOW)
            begin
                fast_env_reg <= env_upd;
            end
            if (state_reg == ST_SLOW_UPD)
            begin
                slow_env_reg <= env_upd;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mag_l_reg <= in_mag_l;
            mag_r_reg <= in_mag_r;
            neg_l_reg <= in_left[SAMPLE_W-1];
            neg_r_reg <= in_right[SAMPLE_W-1];
            pk_reg    <= ENV_W'({in_peak, 8'b0});
        end
        if (state_reg == ST_SUS)
        begin
            acc_reg <= prod[39:0];
        end
        if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_reg + prod[39:0];
        end
        if (state_reg == ST_GAIN)
        begin
            gain_reg <= gain_clamp;
        end
        if (state_reg == ST_SPLIT)
        begin
            // log2 gain in Q16: integer part, table index, interpolation weight
            exp_n_reg  <= exp_sum[37:32];
            frac_i_reg <= exp_sum[31:28];
            frac_r_reg <= exp_sum[27:16];
        end
        if (state_reg == ST_MANT)
        begin
            mant_reg <= tab_base + MANT_W'(interp_rnd[25:12]);
        end
        if (state_reg == ST_RIGHT)
        begin
            left_res_reg <= scaled;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_left_reg    <= left_res_reg;
            out_right_reg   <= scaled;
            out_gain_db_reg <= gain_reg;
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for transient_shaper_gain. Stereo frames go in on the
// slave stream. Each frame is shaped by a bit-exact local copy of the dual
// envelope follower and the dB-to-linear gain, and the m_axis items are
// compared against it. A short table of directed frames and register writes
// comes first, then randomized phases, each with its own register setting.
// ----------------------------------------------------------------------------
module tb;

    import tsg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int IDLE_PCT       = 22;
    localparam int MAX_PRINTS     = 40;

    // not decoded by the block; a write here must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [15:0] gain;
        logic signed [15:0] right;
        logic signed [15:0] left;
    } shaped_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_KNOWN,
        ROW_FRAME
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [23:0]          data;
        logic [15:0]          left;
        logic [15:0]          right;
        logic [15:0]          exp_left;
        logic [15:0]          exp_right;
        logic [15:0]          exp_gain;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    transient_shaper_gain u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shaper model state and registers
    logic [23:0] fast_env;
    logic [23:0] slow_env;
    logic [23:0] fast_att_c;
    logic [23:0] fast_rel_c;
    logic [23:0] slow_att_c;
    logic [23:0] slow_rel_c;
    int          att_sens;
    int          sus_sens;
    int          out_gain;

    // 2^(i/16) in Q16
    int unsigned pow2_frac [17] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
        96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
    };

    shaped_t shaped_frames [$];
    int      mismatches = 0;
    int      rx_count = 0;
    int      quiet_cycles = 0;
    bit      no_idle;
    int      hold_cnt;

    dir_row_t directed_plan [45] = '{
        '{ROW_KNOWN, '0, '0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{ROW_KNOWN, '0, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0},
        '{ROW_KNOWN, '0, '0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0},
        '{ROW_KNOWN, '0, '0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd0},
        '{ROW_KNOWN, '0, '0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'd0},
        // reset coefficients seen through nonzero sensitivities
        '{ROW_WRITE, CFG_ATTACK_SENS, 24'(1500), '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SUSTAIN_SENS, 24'(-700), '0, '0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'(20000), 16'(-3), '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'h8000, 16'd5, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'd0, 16'd0, '0, '0, '0},
        '{ROW_WRITE, CFG_ATTACK_SENS, 24'd0, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SUSTAIN_SENS, 24'd0, '0, '0, '0, '0, '0},
        // largest make-up gain: full scale saturates both ways
        '{ROW_WRITE, CFG_OUTPUT_GAIN, 24'(6144), '0, '0, '0, '0, '0},
        '{ROW_KNOWN, '0, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0},
        '{ROW_KNOWN, '0, '0, 16'(12345), 16'(-12345), 16'h7FFF, 16'h8000, 16'd0},
        '{ROW_FRAME, '0, '0, 16'd1, 16'hFFFF, '0, '0, '0},
        '{ROW_WRITE, CFG_OUTPUT_GAIN, 24'(-6144), '0, '0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'h7FFF, 16'h8000, '0, '0, '0},
        '{ROW_KNOWN, '0, '0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        // zero coefficients: envelopes jump straight to the peak
        '{ROW_WRITE, CFG_OUTPUT_GAIN, 24'd0, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_FAST_ATTACK, 24'd0, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_FAST_RELEASE, 24'd0, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SLOW_ATTACK, 24'd0, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SLOW_RELEASE, 24'd0, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_ATTACK_SENS, 24'(3072), '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SUSTAIN_SENS, 24'(-3072), '0, '0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'h8000, 16'd0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'd0, 16'd0, '0, '0, '0},
        // slow envelope held near full scale, fast one dropped: gain at limit
        '{ROW_WRITE, CFG_SLOW_RELEASE, 24'hFFFFFF, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_ATTACK_SENS, 24'(-3072), '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SUSTAIN_SENS, 24'(3072), '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_OUTPUT_GAIN, 24'(6144), '0, '0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'h8000, 16'h8000, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'd0, 16'd0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'd100, 16'(-100), '0, '0, '0},
        '{ROW_WRITE, CFG_OUTPUT_GAIN, 24'(-6144), '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_ATTACK_SENS, 24'(3072), '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_SUSTAIN_SENS, 24'(-3072), '0, '0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'h8000, 16'h8000, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'd0, 16'd0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'd300, 16'(-7), '0, '0, '0},
        '{ROW_WRITE, CFG_FAST_ATTACK, 24'hFFFFFF, '0, '0, '0, '0, '0},
        '{ROW_WRITE, CFG_UNUSED, 24'hABCDEF, '0, '0, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'h7FFF, 16'h7FFF, '0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'(-5), 16'd9, '0, '0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shaper model
    // ------------------------------------------------------------------
    function automatic logic [16:0] magnitude(input logic signed [15:0] s);
        return (s < 0) ? 17'(-int'(s)) : 17'(int'(s));
    endfunction

    function automatic logic [23:0] follow_env(input logic [23:0] env,
                                               input logic [23:0] pk,
                                               input logic [23:0] att,
                                               input logic [23:0] rel);
        logic [63:0] c;
        logic [63:0] acc;
        c = (pk > env) ? 64'(att) : 64'(rel);
        acc = c * 64'(env) + ((64'd1 << 24) - c) * 64'(pk) + (64'd1 << 23);
        return acc[47:24];
    endfunction

    function automatic logic [15:0] scale_sample(input logic signed [15:0] s,
                                                 input longint unsigned mant,
                                                 input int n);
        longint unsigned p;
        int              sh;
        p = magnitude(s);
        p = p * mant;
        if (n >= 16)
        begin
            p = p << (n - 16);
        end
        else
        begin
            sh = 16 - n;
            p = (p + (64'd1 << (sh - 1))) >> sh;
        end
        if (s < 0)
        begin
            if (p > 32768)
                p = 32768;
            return 16'(64'd0 - p);
        end
        if (p > 32767)
            p = 32767;
        return 16'(p);
    endfunction

    // advance both envelopes by one frame and return the shaped frame
    function automatic shaped_t shape_frame(input logic signed [15:0] l,
                                            input logic signed [15:0] r);
        logic [16:0]     mag_l;
        logic [16:0]     mag_r;
        logic [23:0]     pk;
        longint          trans;
        longint          v;
        longint          g;
        longint          total;
        longint          y;
        int              n;
        int unsigned     fidx;
        longint unsigned frac;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mant;
        shaped_t         res;
        mag_l = magnitude(l);
        mag_r = magnitude(r);
        pk = 24'((mag_l > mag_r) ? mag_l : mag_r) << 8;
        fast_env = follow_env(fast_env, pk, fast_att_c, fast_rel_c);
        slow_env = follow_env(slow_env, pk, slow_att_c, slow_rel_c);

        trans = longint'(fast_env) - longint'(slow_env);
        v = 3 * (longint'(att_sens) * trans + longint'(sus_sens) * longint'(slow_env));
        g = (v + 64'sd4194304) >>> 23;
        if (g > longint'(GAIN_MAX))
            g = longint'(GAIN_MAX);
        if (g < longint'(GAIN_MIN))
            g = longint'(GAIN_MIN);

        // log2 of the linear gain in Q16, offset to keep it positive
        total = g + longint'(out_gain);
        y = ((total * longint'(LOG2_DB_K) + 32768) >>> 16) + (64'sd1 <<< 21);
        n = int'(y >>> 16) - 32;
        fidx = int'((y >>> 12) & 15);
        frac = y & 4095;
        lo = pow2_frac[fidx];
        hi = pow2_frac[fidx + 1];
        mant = lo + (((hi - lo) * frac + 2048) >> 12);

        res.left = scale_sample(l, mant, n);
        res.right = scale_sample(r, mant, n);
        res.gain = 16'(g);
        return res;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FAST_ATTACK:  fast_att_c = data;
            CFG_FAST_RELEASE: fast_rel_c = data;
            CFG_SLOW_ATTACK:  slow_att_c = data;
            CFG_SLOW_RELEASE: slow_rel_c = data;
            CFG_ATTACK_SENS:  att_sens = int'(signed'(data[SENS_W-1:0]));
            CFG_SUSTAIN_SENS: sus_sens = int'(signed'(data[SENS_W-1:0]));
            CFG_OUTPUT_GAIN:  out_gain = int'(signed'(data[OGAIN_W-1:0]));
            default:          ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [23:0] pick_coef();
        case ($urandom_range(5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'hFFFFFF - 24'($urandom_range(4095));
            3:       return 24'hFFFFFF - 24'($urandom_range(262143));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic int pick_level(input int lim);
        case ($urandom_range(4))
            0:       return -lim;
            1:       return lim;
            2:       return 0;
            default: return int'($urandom_range(2 * lim)) - lim;
        endcase
    endfunction

    function automatic logic [15:0] sample_near(input int amp);
        int val;
        val = int'($urandom_range(2 * amp)) - amp;
        if (val > 32767)
            val = 32767;
        return 16'(val);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic send_frame(input logic [15:0] l, input logic [15:0] r,
                              input bit known, input shaped_t typed);
        shaped_t want;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, l};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = shape_frame(l, r);
        if (known)
            want = typed;
        shaped_frames.push_back(want);
    endtask

    // hold off until every frame in flight has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (shaped_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin
        m_axis_tready <= 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (no_idle)
            begin
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(199) == 0)
            begin
                // long stall so the sequencer has to wait on the output
                hold_cnt = $urandom_range(40, 16);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        shaped_t got;
        shaped_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = shaped_t'(m_axis_tdata);
            if (shaped_frames.size() == 0)
            begin
                flag_mismatch($sformatf("item %0d arrived with none pending", rx_count));
            end
            else
            begin
                want = shaped_frames.pop_front();
                if (got.left !== want.left)
                    flag_mismatch($sformatf("item %0d left_out %0d, want %0d",
                                            rx_count, got.left, want.left));
                if (got.right !== want.right)
                    flag_mismatch($sformatf("item %0d right_out %0d, want %0d",
                                            rx_count, got.right, want.right));
                if (got.gain !== want.gain)
                    flag_mismatch($sformatf("item %0d gain_db %0d, want %0d",
                                            rx_count, got.gain, want.gain));
            end
            rx_count++;
        end
    end

    // end the run if no handshake completes for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          amp;
        logic [15:0] l;
        logic [15:0] r;
        shaped_t     typed;
        dir_row_t    row;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        no_idle = 1'b0;
        amp = 1024;

        fast_env = '0;
        slow_env = '0;
        fast_att_c = RST_FAST_ATTACK;
        fast_rel_c = RST_FAST_RELEASE;
        slow_att_c = RST_SLOW_ATTACK;
        slow_rel_c = RST_SLOW_RELEASE;
        att_sens = 0;
        sus_sens = 0;
        out_gain = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[k])
        begin
            row = directed_plan[k];
            if (row.kind == ROW_WRITE)
            begin
                drain();
                write_reg(row.idx, row.data);
            end
            else
            begin
                typed.left = row.exp_left;
                typed.right = row.exp_right;
                typed.gain = row.exp_gain;
                send_frame(row.left, row.right, row.kind == ROW_KNOWN, typed);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            // one phase runs without any idling on either side
            no_idle = (ph == 3);
            write_reg(CFG_FAST_ATTACK, pick_coef());
            write_reg(CFG_FAST_RELEASE, pick_coef());
            write_reg(CFG_SLOW_ATTACK, pick_coef());
            write_reg(CFG_SLOW_RELEASE, pick_coef());
            write_reg(CFG_ATTACK_SENS, 24'(pick_level(3072)));
            write_reg(CFG_SUSTAIN_SENS, 24'(pick_level(3072)));
            write_reg(CFG_OUTPUT_GAIN, 24'(pick_level(6144)));
            if ($urandom_range(1) == 0)
                write_reg(CFG_UNUSED, 24'($urandom));

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // change the program level now and then to make transients
                if ($urandom_range(15) == 0)
                begin
                    case ($urandom_range(4))
                        0:       amp = 0;
                        1:       amp = 64;
                        2:       amp = 1024;
                        3:       amp = 8192;
                        default: amp = 32768;
                    endcase
                end
                case ($urandom_range(19))
                    0:
                    begin
                        l = 16'($urandom);
                        r = 16'($urandom);
                    end
                    1:
                    begin
                        l = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                        r = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                    end
                    default:
                    begin
                        l = sample_near(amp);
                        r = sample_near(amp);
                    end
                endcase
                send_frame(l, r, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        while (shaped_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
